[src/i2crm_pkg.sv]
// Package for the I2C register master: stream payload types, function codes,
// phase encoding, register map and the transmit byte selection.
// Used by all modules of the block; depends on nothing else.
package i2crm_pkg;

   localparam logic [1:0] FUNC_WRITE = 2'd0;
   localparam logic [1:0] FUNC_READ  = 2'd1;
   localparam logic [1:0] FUNC_BURST = 2'd2;
   localparam logic [1:0] FUNC_RSVD  = 2'd3;

   localparam logic [7:0] BURST_WRITE_ADDR = 8'h3C;
   localparam logic [7:0] BURST_READ_ADDR  = 8'h3D;
   localparam logic [7:0] BURST_REG        = 8'h03;
   localparam logic [7:0] MSB_MASK         = 8'h80;

   localparam int BURST_DEPTH = 6;
   localparam logic [2:0] BURST_LAST = 3'd5;
   localparam logic [2:0] BIT_LAST   = 3'd7;

   localparam logic [6:0]  DEV_ADDR_RESET  = 7'd30;
   localparam logic [15:0] HALF_TICK_RESET = 16'd2;

   localparam int CSR_ADDR_W = 3;
   localparam logic CSR_DEV_ADDR_IDX  = 1'b0;
   localparam logic CSR_HALF_TICK_IDX = 1'b1;

   typedef enum logic [14:0] {
      PH_IDLE       = 15'b000000000000001,
      PH_START_A    = 15'b000000000000010,
      PH_START_B    = 15'b000000000000100,
      PH_TX_LOW     = 15'b000000000001000,
      PH_TX_HIGH    = 15'b000000000010000,
      PH_TXACK_LOW  = 15'b000000000100000,
      PH_TXACK_HIGH = 15'b000000001000000,
      PH_RX_LOW     = 15'b000000010000000,
      PH_RX_HIGH    = 15'b000000100000000,
      PH_RXACK_LOW  = 15'b000001000000000,
      PH_RXACK_HIGH = 15'b000010000000000,
      PH_RESTART    = 15'b000100000000000,
      PH_STOP_LOW   = 15'b001000000000000,
      PH_STOP_HIGH  = 15'b010000000000000,
      PH_STOP_END   = 15'b100000000000000
   } phase_type;

   typedef struct packed {
      logic [3:0] pad;
      logic       sda_in;
      logic [7:0] write_data;
      logic [7:0] reg_addr;
      logic [1:0] func;
      logic       start_req;
   } req_type;

   typedef struct packed {
      logic [2:0]         pad;
      logic signed [15:0] axis_z;
      logic signed [15:0] axis_y;
      logic signed [15:0] axis_x;
      logic [7:0]         read_data;
      logic               nack_seen;
      logic               done_res;
      logic               busy_res;
      logic               sda_release;
      logic               scl;
   } rsp_type;

   typedef struct packed {
      logic [6:0]  dev_addr;
      logic [15:0] half_ticks;
   } cfg_type;

   // Byte sent at position k of the write part of a transaction.
   function automatic logic [7:0] tx_byte(input logic [1:0] f, input logic [6:0] dev,
                                          input logic [7:0] ra, input logic [7:0] wd,
                                          input logic [2:0] k);
      logic [7:0] res;
      if (k == 3'd0) begin
         res = (f == FUNC_BURST) ? BURST_WRITE_ADDR : {dev, 1'b0};
      end else if (k == 3'd1) begin
         res = (f == FUNC_BURST) ? BURST_REG : ra;
      end else if (f == FUNC_WRITE) begin
         res = wd;
      end else begin
         res = (f == FUNC_BURST) ? BURST_READ_ADDR : {dev, 1'b1};
      end
      return res;
   endfunction

endpackage

[src/i2crm_csr.sv]
// Configuration registers of the I2C register master behind an APB-style port.
// Depends on i2crm_pkg.
module i2crm_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [i2crm_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]                     csr_pwdata,
   output logic [31:0]                     csr_prdata,
   output logic                            csr_pready,
   output i2crm_pkg::cfg_type              cfg
);

   logic [6:0]  dev_addr_ff;
   logic [15:0] half_ticks_ff;
   logic        wr_en;

   assign csr_pready = 1'b1;
   assign wr_en = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         dev_addr_ff   <= i2crm_pkg::DEV_ADDR_RESET;
         half_ticks_ff <= i2crm_pkg::HALF_TICK_RESET;
      end else if (wr_en) begin
         if (csr_paddr[2] == i2crm_pkg::CSR_DEV_ADDR_IDX) begin
            dev_addr_ff <= csr_pwdata[6:0];
         end else begin
            half_ticks_ff <= csr_pwdata[15:0];
         end
      end
   end

   always_comb begin
      if (csr_paddr[2] == i2crm_pkg::CSR_HALF_TICK_IDX) begin
         csr_prdata = {16'd0, half_ticks_ff};
      end else begin
         csr_prdata = {25'd0, dev_addr_ff};
      end
   end

   assign cfg.dev_addr   = dev_addr_ff;
   assign cfg.half_ticks = half_ticks_ff;

endmodule

[src/i2crm_seq.sv]
// Bus phase sequencer of the I2C register master: holds the transaction state
// and computes one tick's bus levels and status per step. Depends on i2crm_pkg.
module i2crm_seq (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  i2crm_pkg::req_type   req,
   input  i2crm_pkg::cfg_type   cfg,
   output i2crm_pkg::rsp_type   rsp
);

   i2crm_pkg::phase_type phase_ff, phase_in, ph;
   logic [15:0] tick_ff, tick_in, tick;
   logic [2:0]  bit_ff, bit_in, bitc;
   logic [2:0]  byte_ff, byte_in, bytec;
   logic [7:0]  shift_ff, shift_in;
   logic        nack_ff, nack_in, nack;
   logic [1:0]  func_ff, func;
   logic [7:0]  reg_ff, regv;
   logic [7:0]  data_ff, datav;
   logic [7:0]  held_ff, held_in;
   logic [7:0]  burst_ff [i2crm_pkg::BURST_DEPTH];
   logic [7:0]  burst_view [i2crm_pkg::BURST_DEPTH];
   logic        burst_we;
   logic [7:0]  rx_shift;
   logic        take, busy, ph_end, done, scl, rel, rx_last, tx_bit;
   logic [15:0] hp;

   always_comb begin
      take  = (phase_ff == i2crm_pkg::PH_IDLE) && req.start_req
              && (req.func != i2crm_pkg::FUNC_RSVD);
      ph    = take ? i2crm_pkg::PH_START_A : phase_ff;
      tick  = take ? 16'd0 : tick_ff;
      bitc  = take ? 3'd0 : bit_ff;
      bytec = take ? 3'd0 : byte_ff;
      nack  = take ? 1'b0 : nack_ff;
      func  = take ? req.func : func_ff;
      regv  = take ? req.reg_addr : reg_ff;
      datav = take ? req.write_data : data_ff;

      hp      = (cfg.half_ticks == 16'd0) ? 16'd1 : cfg.half_ticks;
      rx_last = (func == i2crm_pkg::FUNC_READ) ? (bytec == 3'd0)
                                               : (bytec >= i2crm_pkg::BURST_LAST);
      tx_bit  = |(shift_ff & (i2crm_pkg::MSB_MASK >> bitc));
      rx_shift = {shift_ff[6:0], req.sda_in};

      scl = 1'b1;
      rel = 1'b1;
      case (ph)
         i2crm_pkg::PH_START_B:    begin scl = 1'b1; rel = 1'b0; end
         i2crm_pkg::PH_TX_LOW:     begin scl = 1'b0; rel = tx_bit; end
         i2crm_pkg::PH_TX_HIGH:    begin scl = 1'b1; rel = tx_bit; end
         i2crm_pkg::PH_TXACK_LOW:  begin scl = 1'b0; rel = 1'b1; end
         i2crm_pkg::PH_RX_LOW:     begin scl = 1'b0; rel = 1'b1; end
         i2crm_pkg::PH_RXACK_LOW:  begin scl = 1'b0; rel = rx_last; end
         i2crm_pkg::PH_RXACK_HIGH: begin scl = 1'b1; rel = rx_last; end
         i2crm_pkg::PH_RESTART:    begin scl = 1'b0; rel = 1'b1; end
         i2crm_pkg::PH_STOP_LOW:   begin scl = 1'b0; rel = 1'b0; end
         i2crm_pkg::PH_STOP_HIGH:  begin scl = 1'b1; rel = 1'b0; end
         default:                  begin scl = 1'b1; rel = 1'b1; end
      endcase

      busy   = (ph != i2crm_pkg::PH_IDLE);
      ph_end = busy && (({1'b0, tick} + 17'd1) >= {1'b0, hp});

      phase_in = ph;
      tick_in  = tick;
      bit_in   = bitc;
      byte_in  = bytec;
      shift_in = take ? shift_ff : shift_ff;
      nack_in  = nack;
      held_in  = held_ff;
      burst_we = 1'b0;
      done     = 1'b0;

      if (busy && !ph_end) begin
         tick_in = tick + 16'd1;
      end else if (ph_end) begin
         tick_in = 16'd0;
         case (ph)
            i2crm_pkg::PH_START_A: phase_in = i2crm_pkg::PH_START_B;
            i2crm_pkg::PH_START_B: begin
               shift_in = i2crm_pkg::tx_byte(func, cfg.dev_addr, regv, datav, bytec);
               bit_in   = 3'd0;
               phase_in = i2crm_pkg::PH_TX_LOW;
            end
            i2crm_pkg::PH_TX_LOW: phase_in = i2crm_pkg::PH_TX_HIGH;
            i2crm_pkg::PH_TX_HIGH: begin
               if (bitc == i2crm_pkg::BIT_LAST) begin
                  phase_in = i2crm_pkg::PH_TXACK_LOW;
               end else begin
                  bit_in   = bitc + 3'd1;
                  phase_in = i2crm_pkg::PH_TX_LOW;
               end
            end
            i2crm_pkg::PH_TXACK_LOW: phase_in = i2crm_pkg::PH_TXACK_HIGH;
            i2crm_pkg::PH_TXACK_HIGH: begin
               nack_in = nack | req.sda_in;
               if (bytec >= 3'd2) begin
                  if (func == i2crm_pkg::FUNC_WRITE) begin
                     phase_in = i2crm_pkg::PH_STOP_LOW;
                  end else begin
                     byte_in  = 3'd0;
                     bit_in   = 3'd0;
                     shift_in = 8'd0;
                     phase_in = i2crm_pkg::PH_RX_LOW;
                  end
               end else if (bytec == 3'd1 && func != i2crm_pkg::FUNC_WRITE) begin
                  byte_in  = 3'd2;
                  phase_in = i2crm_pkg::PH_RESTART;
               end else begin
                  byte_in  = bytec + 3'd1;
                  shift_in = i2crm_pkg::tx_byte(func, cfg.dev_addr, regv, datav,
                                                bytec + 3'd1);
                  bit_in   = 3'd0;
                  phase_in = i2crm_pkg::PH_TX_LOW;
               end
            end
            i2crm_pkg::PH_RESTART: phase_in = i2crm_pkg::PH_START_A;
            i2crm_pkg::PH_RX_LOW:  phase_in = i2crm_pkg::PH_RX_HIGH;
            i2crm_pkg::PH_RX_HIGH: begin
               shift_in = rx_shift;
               if (bitc == i2crm_pkg::BIT_LAST) begin
                  if (func == i2crm_pkg::FUNC_READ) begin
                     held_in = rx_shift;
                  end else if (bytec <= i2crm_pkg::BURST_LAST) begin
                     burst_we = 1'b1;
                  end
                  phase_in = i2crm_pkg::PH_RXACK_LOW;
               end else begin
                  bit_in   = bitc + 3'd1;
                  phase_in = i2crm_pkg::PH_RX_LOW;
               end
            end
            i2crm_pkg::PH_RXACK_LOW: phase_in = i2crm_pkg::PH_RXACK_HIGH;
            i2crm_pkg::PH_RXACK_HIGH: begin
               if (rx_last) begin
                  phase_in = i2crm_pkg::PH_STOP_LOW;
               end else begin
                  byte_in  = bytec + 3'd1;
                  bit_in   = 3'd0;
                  shift_in = 8'd0;
                  phase_in = i2crm_pkg::PH_RX_LOW;
               end
            end
            i2crm_pkg::PH_STOP_LOW:  phase_in = i2crm_pkg::PH_STOP_HIGH;
            i2crm_pkg::PH_STOP_HIGH: phase_in = i2crm_pkg::PH_STOP_END;
            default: begin
               done     = 1'b1;
               phase_in = i2crm_pkg::PH_IDLE;
            end
         endcase
      end

      for (int i = 0; i < i2crm_pkg::BURST_DEPTH; i++) begin
         burst_view[i] = (burst_we && bytec == 3'(i)) ? rx_shift : burst_ff[i];
      end

      rsp.pad         = 3'd0;
      rsp.scl         = scl;
      rsp.sda_release = rel;
      rsp.busy_res    = busy;
      rsp.done_res    = done;
      rsp.nack_seen   = nack_in;
      rsp.read_data   = held_in;
      rsp.axis_x      = {burst_view[0], burst_view[1]};
      rsp.axis_y      = {burst_view[2], burst_view[3]};
      rsp.axis_z      = {burst_view[4], burst_view[5]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= i2crm_pkg::PH_IDLE;
         tick_ff  <= 16'd0;
         bit_ff   <= 3'd0;
         byte_ff  <= 3'd0;
         shift_ff <= 8'd0;
         nack_ff  <= 1'b0;
         func_ff  <= i2crm_pkg::FUNC_WRITE;
         reg_ff   <= 8'd0;
         data_ff  <= 8'd0;
         held_ff  <= 8'd0;
      end else if (step) begin
         phase_ff <= phase_in;
         tick_ff  <= tick_in;
         bit_ff   <= bit_in;
         byte_ff  <= byte_in;
         shift_ff <= shift_in;
         nack_ff  <= nack_in;
         func_ff  <= func;
         reg_ff   <= regv;
         data_ff  <= datav;
         held_ff  <= held_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step && burst_we) begin
         burst_ff[bytec] <= rx_shift;
      end
   end

endmodule

[src/i2c_register_master.sv]
// I2C register master that takes one request item per clock cycle while rsp_tready is high,
// each item being one bus tick, and returns one result item for it through the input register
// and the result register, with the phase sequencer between them. Sustained rate is one item
// per cycle while rsp_tready is high. Depends on i2crm_pkg, i2crm_csr and i2crm_seq.
module i2c_register_master (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // start_req[0], func[2:1], reg_addr[10:3], write_data[18:11], sda_in[19], zero[23:20]
   input  logic [23:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // scl[0], sda_release[1], busy_res[2], done_res[3], nack_seen[4], read_data[12:5],
   // axis_x[28:13], axis_y[44:29], axis_z[60:45], zero[63:61]
   output logic [63:0] rsp_tdata,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   i2crm_pkg::cfg_type cfg;
   i2crm_pkg::req_type in_data_ff;
   i2crm_pkg::rsp_type seq_rsp, out_data_ff;
   logic in_valid_ff, in_valid_in;
   logic out_valid_ff, out_valid_in;
   logic advance;

   i2crm_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   i2crm_seq u_seq (
      .clock (clock),
      .reset (reset),
      .step  (advance),
      .req   (in_data_ff),
      .cfg   (cfg),
      .rsp   (seq_rsp)
   );

   assign advance      = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready   = !in_valid_ff || advance;
   assign in_valid_in  = (req_tvalid && req_tready) || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_data_ff <= req_tdata;
      end
      if (advance) begin
         out_data_ff <= seq_rsp;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

   assert property (@(posedge clock) disable iff (reset)
      !out_valid_ff |-> req_tready)
      else $error("Input stalled while the result register is empty.");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !out_data_ff.busy_res) |-> (out_data_ff.scl && out_data_ff.sda_release))
      else $error("Bus not released in an idle tick.");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && out_data_ff.done_res) |-> out_data_ff.busy_res)
      else $error("Stop completion reported outside a transaction.");

   assert property (@(posedge clock)
      reset |=> (!rsp_tvalid && !in_valid_ff))
      else $error("Pipeline holds an item after reset.");

endmodule
